// ===== src/bpa_pkg.sv =====
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int DEF_NUM_PAGES = 1024;
  localparam int DEF_MAX_ORDER = 9;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_NOT_USED  = 2'd3;

endpackage

// ===== src/bpa_ram.sv =====
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/buddy_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// channel | ports                         | word
// --------+-------------------------------+-------------------------------------------
// in      | in_tvalid/in_tready/in_tdata  | tdata: block_order, page_index; tuser: opcode
// out     | out_tvalid/out_tready/out_tdata | tdata: status, result_page, result_order
//
// One request at a time through a single page-entry RAM (one write, one
// registered read per cycle). Allocate: search the free lists up from the order,
// unlink the block, mark it used, then split it, appending each upper half to
// its list. Free: clear the used bit, merge with each free buddy, then append
// the block. After reset a clearing pass writes all NUM_PAGES entries; no word
// is taken until it ends. A stalled result holds the block in its output state.
module buddy_page_allocator_unit #(
  parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES,
  parameter int MAX_ORDER = bpa_pkg::DEF_MAX_ORDER
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // block_order[3:0], page_index[13:4], pad
  input  logic [0:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], result_page[11:2], result_order[15:12]
);

  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int LW = $clog2(NUM_PAGES + 1);
  localparam int OW = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int CW = $clog2(MAX_ORDER + 2);
  localparam int TOP = 1 << MAX_ORDER;
  localparam int NTOP = NUM_PAGES / TOP;
  localparam logic [LW-1:0] NO_LINK = LW'(NUM_PAGES);
  localparam logic [LW-1:0] HEAD0 = (NTOP > 0) ? LW'(0) : NO_LINK;
  localparam logic [LW-1:0] TAIL0 = (NTOP > 0) ? LW'((NTOP - 1) * TOP) : NO_LINK;

  typedef struct packed {
    logic          used;
    logic          has;
    logic [OW-1:0] ord;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } ent_t;

  localparam int EW = $bits(ent_t);

  typedef enum logic [21:0] {
    S_INIT   = 22'h000001,
    S_IDLE   = 22'h000002,
    S_SEARCH = 22'h000004,
    S_RM_A   = 22'h000008,
    S_RM_B   = 22'h000010,
    S_RM_C   = 22'h000020,
    S_RM_D   = 22'h000040,
    S_RM_E   = 22'h000080,
    S_RM_F   = 22'h000100,
    S_AL_MK  = 22'h000200,
    S_SPLIT  = 22'h000400,
    S_AP_A   = 22'h000800,
    S_AP_B   = 22'h001000,
    S_AP_C   = 22'h002000,
    S_FR_A   = 22'h004000,
    S_FR_B   = 22'h008000,
    S_MG_A   = 22'h010000,
    S_MG_B   = 22'h020000,
    S_FX_B   = 22'h040000,
    S_FX_PA  = 22'h080000,
    S_FX_PB  = 22'h100000,
    S_OUT    = 22'h200000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] c_r, c_nxt, want_r, want_nxt;
  logic [PW-1:0] p_r, p_nxt, tgt_r, tgt_nxt, i_r, i_nxt, rpage_r, rpage_nxt;
  logic [LW-1:0] pr_r, pr_nxt, nx_r, nx_nxt, t_r, t_nxt;
  logic [CW-1:0] rord_r, rord_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          op_r, op_nxt;
  ent_t          e_r, e_nxt;

  logic [LW-1:0] head_r [MAX_ORDER+1];
  logic [LW-1:0] tail_r [MAX_ORDER+1];
  logic          hd_we, tl_we;
  logic [LW-1:0] hd_val, tl_val;
  logic [OW-1:0] hidx;
  logic [LW-1:0] head_cur, tail_cur;

  logic          ram_we;
  logic [PW-1:0] ram_wa, ram_ra;
  ent_t          ram_wd, rd_ent;
  logic [EW-1:0] ram_rdata;

  logic [31:0]   pw32, iw32, split_b, merge_b;
  logic [CW-1:0] cdec, cinc;
  logic [3:0]    in_order;
  logic [9:0]    in_page;
  logic [PW+9:0] in_page_ext, out_page_ext;
  logic [CW+3:0] out_ord_ext;
  ent_t          init_ent;

  bpa_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rdata)
  );

  assign rd_ent      = ram_rdata;
  assign in_order    = in_tdata[3:0];
  assign in_page     = in_tdata[13:4];
  assign in_page_ext = {{PW{1'b0}}, in_page};
  assign pw32        = 32'(p_r);
  assign iw32        = 32'(i_r);
  assign cdec        = c_r - 1'b1;
  assign cinc        = c_r + 1'b1;
  assign split_b     = pw32 ^ (32'd1 << cdec);
  assign merge_b     = pw32 ^ (32'd1 << c_r);
  assign hidx        = (32'(c_r) > MAX_ORDER) ? '0 : c_r[OW-1:0];
  assign head_cur    = head_r[hidx];
  assign tail_cur    = tail_r[hidx];

  always_comb begin
    init_ent = '0;
    init_ent.nxt = NO_LINK;
    init_ent.prv = NO_LINK;
    if ((iw32 & 32'(TOP - 1)) == 32'd0 && iw32 + 32'(TOP) <= 32'(NUM_PAGES)) begin
      init_ent.has = 1'b1;
      init_ent.ord = OW'(MAX_ORDER);
      if (iw32 + 32'(2 * TOP) <= 32'(NUM_PAGES)) begin
        init_ent.nxt = LW'(iw32 + 32'(TOP));
      end
      if (iw32 != 32'd0) begin
        init_ent.prv = LW'(iw32 - 32'(TOP));
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    want_nxt  = want_r;
    p_nxt     = p_r;
    tgt_nxt   = tgt_r;
    i_nxt     = i_r;
    pr_nxt    = pr_r;
    nx_nxt    = nx_r;
    t_nxt     = t_r;
    e_nxt     = e_r;
    op_nxt    = op_r;
    st_nxt    = st_r;
    rpage_nxt = rpage_r;
    rord_nxt  = rord_r;
    ram_we    = 1'b0;
    ram_wa    = tgt_r;
    ram_wd    = rd_ent;
    ram_ra    = tgt_r;
    hd_we     = 1'b0;
    hd_val    = LW'(tgt_r);
    tl_we     = 1'b0;
    tl_val    = LW'(tgt_r);
    in_tready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        ram_we = 1'b1;
        ram_wa = i_r;
        ram_wd = init_ent;
        i_nxt  = i_r + 1'b1;
        if (32'(i_r) == NUM_PAGES - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser[0];
          rpage_nxt = '0;
          rord_nxt  = '0;
          if (in_tuser[0] == bpa_pkg::OP_ALLOC) begin
            if (32'(in_order) > MAX_ORDER) begin
              st_nxt    = bpa_pkg::ST_BAD_ORDER;
              state_nxt = S_OUT;
            end else begin
              c_nxt     = CW'(in_order);
              want_nxt  = CW'(in_order);
              state_nxt = S_SEARCH;
            end
          end else begin
            p_nxt = in_page_ext[PW-1:0];
            if (32'(in_page) >= NUM_PAGES) begin
              st_nxt    = bpa_pkg::ST_NOT_USED;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_FR_A;
            end
          end
        end
      end
      S_SEARCH: begin
        if (32'(c_r) > MAX_ORDER) begin
          st_nxt    = bpa_pkg::ST_NO_SPACE;
          state_nxt = S_OUT;
        end else if (head_cur == NO_LINK) begin
          c_nxt = cinc;
        end else begin
          p_nxt     = head_cur[PW-1:0];
          tgt_nxt   = head_cur[PW-1:0];
          state_nxt = S_RM_A;
        end
      end
      S_RM_A: begin
        ram_ra    = tgt_r;
        state_nxt = S_RM_B;
      end
      S_RM_B: begin
        e_nxt  = rd_ent;
        pr_nxt = rd_ent.prv;
        nx_nxt = rd_ent.nxt;
        if (rd_ent.prv != NO_LINK) begin
          ram_ra    = rd_ent.prv[PW-1:0];
          state_nxt = S_RM_C;
        end else begin
          hd_we     = 1'b1;
          hd_val    = rd_ent.nxt;
          state_nxt = S_RM_D;
        end
      end
      S_RM_C: begin
        ram_we     = 1'b1;
        ram_wa     = pr_r[PW-1:0];
        ram_wd     = rd_ent;
        ram_wd.nxt = nx_r;
        state_nxt  = S_RM_D;
      end
      S_RM_D: begin
        if (nx_r != NO_LINK) begin
          ram_ra    = nx_r[PW-1:0];
          state_nxt = S_RM_E;
        end else begin
          tl_we     = 1'b1;
          tl_val    = pr_r;
          state_nxt = S_RM_F;
        end
      end
      S_RM_E: begin
        ram_we     = 1'b1;
        ram_wa     = nx_r[PW-1:0];
        ram_wd     = rd_ent;
        ram_wd.prv = pr_r;
        state_nxt  = S_RM_F;
      end
      S_RM_F: begin
        state_nxt = (op_r == bpa_pkg::OP_ALLOC) ? S_AL_MK : S_FX_B;
      end
      S_AL_MK: begin
        ram_we      = 1'b1;
        ram_wa      = p_r;
        ram_wd      = e_r;
        ram_wd.used = 1'b1;
        ram_wd.has  = 1'b1;
        ram_wd.ord  = want_r[OW-1:0];
        state_nxt   = S_SPLIT;
      end
      S_SPLIT: begin
        if (c_r > want_r) begin
          c_nxt = cdec;
          if (split_b < 32'(NUM_PAGES)) begin
            tgt_nxt   = PW'(split_b);
            state_nxt = S_AP_A;
          end
        end else begin
          st_nxt    = bpa_pkg::ST_OK;
          rpage_nxt = p_r;
          rord_nxt  = want_r;
          state_nxt = S_OUT;
        end
      end
      S_AP_A: begin
        ram_ra    = tgt_r;
        t_nxt     = tail_cur;
        state_nxt = S_AP_B;
      end
      S_AP_B: begin
        ram_we     = 1'b1;
        ram_wa     = tgt_r;
        ram_wd     = rd_ent;
        ram_wd.prv = t_r;
        ram_wd.nxt = NO_LINK;
        ram_wd.has = 1'b1;
        ram_wd.ord = c_r[OW-1:0];
        tl_we      = 1'b1;
        if (t_r != NO_LINK) begin
          ram_ra    = t_r[PW-1:0];
          state_nxt = S_AP_C;
        end else begin
          hd_we = 1'b1;
          if (op_r == bpa_pkg::OP_ALLOC) begin
            state_nxt = S_SPLIT;
          end else begin
            st_nxt    = bpa_pkg::ST_OK;
            rpage_nxt = p_r;
            rord_nxt  = c_r;
            state_nxt = S_OUT;
          end
        end
      end
      S_AP_C: begin
        ram_we     = 1'b1;
        ram_wa     = t_r[PW-1:0];
        ram_wd     = rd_ent;
        ram_wd.nxt = LW'(tgt_r);
        if (op_r == bpa_pkg::OP_ALLOC) begin
          state_nxt = S_SPLIT;
        end else begin
          st_nxt    = bpa_pkg::ST_OK;
          rpage_nxt = p_r;
          rord_nxt  = c_r;
          state_nxt = S_OUT;
        end
      end
      S_FR_A: begin
        ram_ra    = p_r;
        state_nxt = S_FR_B;
      end
      S_FR_B: begin
        if (!rd_ent.used) begin
          st_nxt    = bpa_pkg::ST_NOT_USED;
          state_nxt = S_OUT;
        end else begin
          ram_we      = 1'b1;
          ram_wa      = p_r;
          ram_wd      = rd_ent;
          ram_wd.used = 1'b0;
          c_nxt       = (32'(rd_ent.ord) > MAX_ORDER) ? CW'(MAX_ORDER) : CW'(rd_ent.ord);
          state_nxt   = S_MG_A;
        end
      end
      S_MG_A: begin
        if (32'(c_r) >= MAX_ORDER || merge_b >= 32'(NUM_PAGES)) begin
          tgt_nxt   = p_r;
          state_nxt = S_AP_A;
        end else begin
          tgt_nxt   = PW'(merge_b);
          ram_ra    = PW'(merge_b);
          state_nxt = S_MG_B;
        end
      end
      S_MG_B: begin
        if (!rd_ent.has || rd_ent.ord != c_r[OW-1:0] || rd_ent.used) begin
          tgt_nxt   = p_r;
          state_nxt = S_AP_A;
        end else begin
          state_nxt = S_RM_A;
        end
      end
      S_FX_B: begin
        ram_we = 1'b1;
        ram_wa = tgt_r;
        ram_wd = e_r;
        if (tgt_r < p_r) begin
          ram_wd.has = 1'b1;
          ram_wd.ord = cinc[OW-1:0];
        end else begin
          ram_wd.has = 1'b0;
          ram_wd.ord = '0;
        end
        state_nxt = S_FX_PA;
      end
      S_FX_PA: begin
        ram_ra    = p_r;
        state_nxt = S_FX_PB;
      end
      S_FX_PB: begin
        ram_we = 1'b1;
        ram_wa = p_r;
        ram_wd = rd_ent;
        if (p_r < tgt_r) begin
          ram_wd.has = 1'b1;
          ram_wd.ord = cinc[OW-1:0];
        end else begin
          ram_wd.has = 1'b0;
          ram_wd.ord = '0;
          p_nxt      = tgt_r;
        end
        c_nxt     = cinc;
        state_nxt = S_MG_A;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      i_r     <= '0;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        head_r[k] <= (k == MAX_ORDER) ? HEAD0 : NO_LINK;
        tail_r[k] <= (k == MAX_ORDER) ? TAIL0 : NO_LINK;
      end
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      if (hd_we) begin
        head_r[hidx] <= hd_val;
      end
      if (tl_we) begin
        tail_r[hidx] <= tl_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    want_r  <= want_nxt;
    p_r     <= p_nxt;
    tgt_r   <= tgt_nxt;
    pr_r    <= pr_nxt;
    nx_r    <= nx_nxt;
    t_r     <= t_nxt;
    e_r     <= e_nxt;
    op_r    <= op_nxt;
    st_r    <= st_nxt;
    rpage_r <= rpage_nxt;
    rord_r  <= rord_nxt;
  end

  assign out_page_ext = {10'd0, rpage_r};
  assign out_ord_ext  = {4'd0, rord_r};
  assign out_tvalid   = (state_r == S_OUT);
  assign out_tdata    = {out_ord_ext[3:0], out_page_ext[9:0], st_r};

endmodule
